// ===== hw/rtl/bgsc_pkg.sv =====
// ============================================================================
// bgsc_pkg: shared types and constants for the binary GCD block
// Holds the iteration counter and common-shift types and their limits.
// ============================================================================
package bgsc_pkg;

    localparam int COUNT_W = 7;
    localparam int SHIFT_W = 6;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SHIFT_W-1:0] shift_t;

    localparam count_t COUNT_MAX = {COUNT_W{1'b1}};
    localparam shift_t SHIFT_MAX = {SHIFT_W{1'b1}};

endpackage

// ===== hw/rtl/binary_gcd_with_step_count.sv =====
// ============================================================================
// binary_gcd_with_step_count: iterative binary GCD with iteration count
// Computes gcd(operand_a, operand_b) by repeated halving and subtraction
// and reports how many loop iterations were taken.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall / operand_a / operand_b): a transfer
//   occurs on a rising edge with in_valid high and in_stall low. in_stall is
//   high while an item is being worked on, so one item is processed at a time.
//   Output channel (out_valid / out_stall / gcd_value / step_count): one
//   result per input item, held in an output register until the receiver
//   takes it with out_stall low.
//   Operation: the operands load at the transfer, then the single shared
//   halve / compare / subtract unit runs the loop, one iteration a cycle,
//   counting iterations in step_count; once a working value is zero the
//   result is registered and out_valid rises. A zero operand gives
//   gcd_value 0 and step_count 0.
//   The next input is accepted as soon as the result is registered, even if
//   the output still waits. If the receiver stalls while a finished result is
//   pending, the sequencer holds its final values until the register frees.
//   Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
//   any pending result.
// ============================================================================
module binary_gcd_with_step_count #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OPERAND_WIDTH-1:0] operand_a,
    input  logic [OPERAND_WIDTH-1:0] operand_b,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [OPERAND_WIDTH-1:0] gcd_value,
    output bgsc_pkg::count_t         step_count
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Sequencer and working registers
    logic                     state_reg, state_next;
    logic [OPERAND_WIDTH-1:0] small_reg, small_next;
    logic [OPERAND_WIDTH-1:0] large_reg, large_next;
    bgsc_pkg::shift_t         shift_reg, shift_next;
    bgsc_pkg::count_t         count_reg, count_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic [OPERAND_WIDTH-1:0] gcd_reg, gcd_next;
    bgsc_pkg::count_t         cnt_out_reg, cnt_out_next;

    // Shared iteration unit
    logic                     small_even;
    logic                     large_even;
    logic [OPERAND_WIDTH-1:0] small_half;
    logic [OPERAND_WIDTH-1:0] large_half;
    logic                     swap;
    logic [OPERAND_WIDTH-1:0] iter_lo;
    logic [OPERAND_WIDTH-1:0] iter_hi;
    bgsc_pkg::shift_t         shift_inc;
    bgsc_pkg::count_t         count_inc;

    logic                     in_xfer;
    logic                     loop_done;
    logic                     out_free;
    logic [OPERAND_WIDTH:0]   value_sum;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_xfer    = in_valid && !in_stall;
    assign loop_done  = (small_reg == '0) || (large_reg == '0);
    assign out_free   = !out_valid_reg || !out_stall;
    assign value_sum  = {1'b0, small_reg} + {1'b0, large_reg};

    assign out_valid  = out_valid_reg;
    assign gcd_value  = gcd_reg;
    assign step_count = cnt_out_reg;

    // One loop iteration: halve the even value(s), order, subtract.
    always_comb
    begin
        small_even = !small_reg[0];
        large_even = !large_reg[0];
        small_half = small_reg;
        large_half = large_reg;
        shift_inc  = shift_reg;
        if (small_even)
        begin
            small_half = small_reg >> 1;
            if (large_even)
            begin
                large_half = large_reg >> 1;
                if (shift_reg != bgsc_pkg::SHIFT_MAX)
                begin
                    shift_inc = bgsc_pkg::shift_t'(shift_reg + 1'b1);
                end
            end
        end
        else if (large_even)
        begin
            large_half = large_reg >> 1;
        end

        swap    = (large_half < small_half);
        iter_lo = swap ? large_half : small_half;
        iter_hi = swap ? small_half : large_half;

        if (count_reg != bgsc_pkg::COUNT_MAX)
        begin
            count_inc = bgsc_pkg::count_t'(count_reg + 1'b1);
        end
        else
        begin
            count_inc = count_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        small_next     = small_reg;
        large_next     = large_reg;
        shift_next     = shift_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        gcd_next       = gcd_reg;
        cnt_out_next   = cnt_out_reg;

        // Drop the pending result once the receiver takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    // Load the smaller operand as small, the larger as large.
                    if (operand_a < operand_b)
                    begin
                        small_next = operand_a;
                        large_next = operand_b;
                    end
                    else
                    begin
                        small_next = operand_b;
                        large_next = operand_a;
                    end
                    shift_next = '0;
                    count_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!loop_done)
                begin
                    // Advance one iteration.
                    small_next = iter_lo;
                    large_next = iter_hi - iter_lo;
                    shift_next = shift_inc;
                    count_next = count_inc;
                end
                else if (out_free)
                begin
                    // Restore the common power of two and register the result.
                    gcd_next       = small_reg << shift_reg;
                    cnt_out_next   = count_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                // otherwise hold the finished values until the output frees
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working values
    always_ff @(posedge clk)
    begin
        small_reg   <= small_next;
        large_reg   <= large_next;
        shift_reg   <= shift_next;
        count_reg   <= count_next;
        gcd_reg     <= gcd_next;
        cnt_out_reg <= cnt_out_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A transfer on the input always starts the loop.
    a_xfer_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_RUN))
        else $error("accepted item did not start the loop");

    // Every iteration strictly reduces small + large, so the loop terminates.
    a_sum_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && !loop_done |=> (value_sum < $past(value_sum)))
        else $error("iteration did not reduce the working values");

    // The iteration count never goes backwards within an item.
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && !loop_done |=> (count_reg >= $past(count_reg)))
        else $error("iteration count went backwards");

    // Zero iterations means a zero operand, hence a zero result, and vice versa.
    a_zero_count_zero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (cnt_out_reg == '0) |-> (gcd_reg == '0))
        else $error("no iterations but nonzero result");

    a_nonzero_count_nonzero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (cnt_out_reg != '0) |-> (gcd_reg != '0))
        else $error("iterations taken but zero result");

endmodule
